/* design/shabsh_pkg.sv */
package shabsh_pkg;

  typedef logic [0:7][31:0]  hash_t;
  typedef logic [0:15][31:0] block_t;

  typedef struct packed {
    logic start;
    logic init;
  } core_ctl_t;

  localparam logic MODE_ABSORB = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] PAD_FILL  = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST = 3'd7;
  localparam logic [5:0] ROUND_LAST = 6'd63;

  localparam hash_t HASH_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

/* design/shabsh_core.sv */
module shabsh_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  shabsh_pkg::core_ctl_t ctl,
  input  shabsh_pkg::block_t   blk,
  output logic                 busy,
  output shabsh_pkg::hash_t    hash
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  shabsh_pkg::hash_t  hash_r, hash_nxt;
  shabsh_pkg::hash_t  work_r, work_nxt;
  shabsh_pkg::block_t win_r, win_nxt;
  logic [5:0]         rnd_r, rnd_nxt;
  logic               run_r, run_nxt;
  logic               fin_r, fin_nxt;

  logic [31:0] big1, choose, t1, big0, major, t2, sig0, sig1, w_new;

  // One round of the compression and one step of the message schedule
  always_comb begin
    big1   = rotr(work_r[4], 6) ^ rotr(work_r[4], 11) ^ rotr(work_r[4], 25);
    choose = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
    t1     = work_r[7] + big1 + choose + shabsh_pkg::ROUND_K[rnd_r] + win_r[0];
    big0   = rotr(work_r[0], 2) ^ rotr(work_r[0], 13) ^ rotr(work_r[0], 22);
    major  = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]);
    t2     = big0 + major;
    sig0   = rotr(win_r[1], 7) ^ rotr(win_r[1], 18) ^ (win_r[1] >> 3);
    sig1   = rotr(win_r[14], 17) ^ rotr(win_r[14], 19) ^ (win_r[14] >> 10);
    w_new  = win_r[0] + sig0 + win_r[9] + sig1;
  end

  always_comb begin
    hash_nxt = hash_r;
    work_nxt = work_r;
    win_nxt  = win_r;
    rnd_nxt  = rnd_r;
    run_nxt  = run_r;
    fin_nxt  = fin_r;
    priority if (ctl.init) begin
      hash_nxt = shabsh_pkg::HASH_IV;
    end else if (ctl.start) begin
      win_nxt  = blk;
      work_nxt = hash_r;
      rnd_nxt  = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      for (int i = 0; i < 15; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      win_nxt[15] = w_new;
      work_nxt = {t1 + t2, work_r[0], work_r[1], work_r[2],
                  work_r[3] + t1, work_r[4], work_r[5], work_r[6]};
      rnd_nxt  = rnd_r + 6'd1;
      if (rnd_r == shabsh_pkg::ROUND_LAST) begin
        run_nxt = 1'b0;
        fin_nxt = 1'b1;
      end
    end else if (fin_r) begin
      // fold the working variables back into the chaining value
      for (int i = 0; i < 8; i++) begin
        hash_nxt[i] = hash_r[i] + work_r[i];
      end
      fin_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= shabsh_pkg::HASH_IV;
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      rnd_r  <= '0;
    end else begin
      hash_r <= hash_nxt;
      run_r  <= run_nxt;
      fin_r  <= fin_nxt;
      rnd_r  <= rnd_nxt;
    end
    work_r <= work_nxt;
    win_r  <= win_nxt;
  end

  assign busy = run_r | fin_r;
  assign hash = hash_r;

endmodule

/* design/sha256_byte_stream_hasher.sv */
// SHA-256 over a byte stream. Each input word with in_mode low appends
// in_data_byte to the message; a word with in_mode high pads the message,
// runs the last block(s) and then delivers the eight digest words, index 0
// first, with out_last_word set on index 7, after which the hasher is ready
// for a new message with no reset needed. A plain byte causes no stall; the
// byte that fills a 64-byte block holds in_stall high while the shared round
// unit runs its 64 rounds, one per cycle, plus the load and final-add steps.
// A finish feeds its padding one byte per cycle through the same block buffer
// (64 minus the bytes buffered, or that plus 64 when 56 or more are buffered)
// with a compression after each full block, then emits the digest one word per
// cycle as the output side takes them. The round unit and a stalled output
// side both limit throughput.
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_COMP,
    ST_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  state_t             ret_r, ret_nxt;       // where to go once a block is compressed
  logic               go_r, go_nxt;         // start pulse for the round unit
  logic               first_r, first_nxt;   // pad marker byte still to push
  logic [5:0]         fill_r, fill_nxt;
  logic [60:0]        nbytes_r, nbytes_nxt; // message length in bytes, mod 2^61
  logic [63:0]        len_r, len_nxt;       // latched bit length, shifted out MSB first
  logic [511:0]       buf_r, buf_nxt;
  logic [2:0]         emit_idx_r, emit_idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_word_r, out_word_nxt;
  logic [2:0]         out_idx_r, out_idx_nxt;
  logic               out_last_r, out_last_nxt;

  logic               push;
  logic [7:0]         push_byte;
  logic               in_take;
  logic               out_load;
  shabsh_pkg::core_ctl_t core_ctl;
  logic               core_busy;
  shabsh_pkg::hash_t  core_hash;

  shabsh_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (core_ctl),
    .blk   (shabsh_pkg::block_t'(buf_r)),
    .busy  (core_busy),
    .hash  (core_hash)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    go_nxt        = 1'b0;
    first_nxt     = first_r;
    nbytes_nxt    = nbytes_r;
    len_nxt       = len_r;
    emit_idx_nxt  = emit_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    push          = 1'b0;
    push_byte     = '0;
    core_ctl      = '{start: go_r, init: 1'b0};

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          if (in_mode == shabsh_pkg::MODE_ABSORB) begin
            push       = 1'b1;
            push_byte  = in_data_byte;
            nbytes_nxt = nbytes_r + 61'd1;
            if (fill_r == shabsh_pkg::FILL_LAST) begin
              state_nxt = ST_COMP;
              ret_nxt   = ST_IDLE;
              go_nxt    = 1'b1;
            end
          end else begin
            // latch the bit count and clear it for the next message
            len_nxt    = {nbytes_r, 3'b000};
            nbytes_nxt = '0;
            first_nxt  = 1'b1;
            state_nxt  = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (first_r || fill_r != shabsh_pkg::PAD_FILL) begin
          push      = 1'b1;
          push_byte = first_r ? shabsh_pkg::PAD_BYTE : 8'h00;
          first_nxt = 1'b0;
          if (fill_r == shabsh_pkg::FILL_LAST) begin
            state_nxt = ST_COMP;
            ret_nxt   = ST_PAD;
            go_nxt    = 1'b1;
          end
        end else begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        push      = 1'b1;
        push_byte = len_r[63:56];
        len_nxt   = {len_r[55:0], 8'h00};
        if (fill_r == shabsh_pkg::FILL_LAST) begin
          state_nxt = ST_COMP;
          ret_nxt   = ST_EMIT;
          go_nxt    = 1'b1;
        end
      end
      ST_COMP: begin
        // wait while the start pulse is out, then until the round unit is done
        if (!go_r && !core_busy) begin
          state_nxt    = ret_r;
          emit_idx_nxt = '0;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = core_hash[emit_idx_r];
          out_idx_nxt   = emit_idx_r;
          out_last_nxt  = (emit_idx_r == shabsh_pkg::WORD_LAST);
          emit_idx_nxt  = emit_idx_r + 3'd1;
          if (emit_idx_r == shabsh_pkg::WORD_LAST) begin
            core_ctl.init = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Advance the block buffer one byte per push; first byte lands in the top lane
  always_comb begin
    buf_nxt  = buf_r;
    fill_nxt = fill_r;
    if (push) begin
      buf_nxt  = {buf_r[503:0], push_byte};
      fill_nxt = fill_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      go_r        <= 1'b0;
      first_r     <= 1'b0;
      fill_r      <= '0;
      nbytes_r    <= '0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      go_r        <= go_nxt;
      first_r     <= first_nxt;
      fill_r      <= fill_nxt;
      nbytes_r    <= nbytes_nxt;
      emit_idx_r  <= emit_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    len_r      <= len_nxt;
    buf_r      <= buf_nxt;
    out_word_r <= out_word_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_last_word   = out_last_r;

  // Hold off input whenever the round unit is working
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    core_busy |-> in_stall)
    else $error("input accepted while compression in progress");

  // Length bytes always close out a block that already holds 56 bytes
  a_len_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LEN) |-> (fill_r >= shabsh_pkg::PAD_FILL))
    else $error("length bytes pushed at wrong block offset");

  // The last digest word carries the top index
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_word) |-> (out_word_index == shabsh_pkg::WORD_LAST))
    else $error("last word flag on wrong index");

  // The round unit never starts while the buffer is partly filled
  a_start_full: assert property (@(posedge clk) disable iff (!rst_n)
    go_r |-> (fill_r == '0))
    else $error("compression started on a partial block");

endmodule

/* sim/tb.sv */
module tb;

  // Bound on the whole run, in clock cycles.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Quiet cycles after the last digest word, to catch anything extra.
  localparam int unsigned TAIL_CYCLES = 300;
  // Rough number of input words to push through the hasher.
  localparam int unsigned WORD_TARGET = 430;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Running SHA-256 of the accepted byte stream plus the digest words that
  // are still owed by the hasher, oldest first.
  class digest_scoreboard;
    typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
    } digest_word_t;

    logic [31:0]  chain [8];
    logic [7:0]   buffer [64];
    int unsigned  fill;
    logic [63:0]  bit_count;
    digest_word_t awaited [$];
    int unsigned  errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      foreach (chain[i]) chain[i] = SHA_IV[i];
      fill = 0;
      bit_count = '0;
    endfunction

    function logic [31:0] rotr(logic [31:0] v, int n);
      return (v >> n) | (v << (32 - n));
    endfunction

    function void compress_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++)
        w[i] = {buffer[4*i], buffer[4*i+1], buffer[4*i+2], buffer[4*i+3]};
      for (int i = 16; i < 64; i++)
        w[i] = w[i-16] + w[i-7]
             + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
             + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
      {a, b, c, d} = {chain[0], chain[1], chain[2], chain[3]};
      {e, f, g, h} = {chain[4], chain[5], chain[6], chain[7]};
      for (int i = 0; i < 64; i++) begin
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + SHA_K[i] + w[i];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    // Advance the hash by one accepted input word.
    function void note_word(logic mode, logic [7:0] data);
      digest_word_t owed_word;
      if (mode == shabsh_pkg::MODE_ABSORB) begin
        buffer[fill] = data;
        bit_count += 64'd8;
        fill++;
        if (fill == 64) begin
          compress_block();
          fill = 0;
        end
        return;
      end
      // Finish: pad, close out one or two blocks, queue the digest.
      buffer[fill] = 8'h80;
      fill++;
      if (fill > 56) begin
        for (int i = fill; i < 64; i++) buffer[i] = 8'h00;
        compress_block();
        fill = 0;
      end
      for (int i = fill; i < 56; i++) buffer[i] = 8'h00;
      for (int i = 0; i < 8; i++) buffer[56+i] = bit_count[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        owed_word.word  = chain[i];
        owed_word.index = 3'(i);
        owed_word.last  = (3'(i) == shabsh_pkg::WORD_LAST);
        awaited.insert(awaited.size(), owed_word);
      end
      restart();
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    // Compare one accepted digest word against the oldest one owed.
    task check_result(logic [31:0] word, logic [2:0] index, logic last);
      digest_word_t owed;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected digest word %h index %0d", word, index));
        return;
      end
      owed = awaited.pop_front();
      if (word !== owed.word)
        report($sformatf("digest word %0d: got %h, want %h", owed.index, word, owed.word));
      if (index !== owed.index)
        report($sformatf("word index: got %0d, want %0d", index, owed.index));
      if (last !== owed.last)
        report($sformatf("last flag at index %0d: got %b, want %b", owed.index, last,
                         owed.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_mode;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  digest_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned words_sent = 0;
  // High during the stretch where neither side idles.
  logic calm = 1'b0;

  sha256_byte_stream_hasher DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: stall at random outside the calm stretch, so stalls land on
  // every digest word position and also while nothing is pending.
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 12);
  end

  // Sample on the rising edge; a digest word moves when valid and not stalled.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_digest_word, out_word_index, out_last_word);
  end

  // Present one input word at the falling edge and hold it until accepted.
  // Random idle cycles come first, except in the calm stretch.
  task automatic send_word(logic mode, logic [7:0] data);
    while (!calm && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_data_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(mode, data);
    words_sent++;
    calm = (words_sent >= 180) && (words_sent < 300);
    @(negedge clk);
  endtask

  // A whole message: len random bytes, then a finish with a junk data byte.
  task automatic send_message(int unsigned len);
    repeat (len) send_word(shabsh_pkg::MODE_ABSORB, 8'($urandom));
    send_word(shabsh_pkg::MODE_FINISH, 8'($urandom));
  endtask

  // Drop valid and hold off until every owed digest word has come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned len;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_mode      = shabsh_pkg::MODE_ABSORB;
    in_data_byte = 8'h00;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty message, then a second finish straight after it.
    send_word(shabsh_pkg::MODE_FINISH, 8'h00);
    send_word(shabsh_pkg::MODE_FINISH, 8'hff);
    // "abc", the classic short vector.
    send_word(shabsh_pkg::MODE_ABSORB, 8'h61);
    send_word(shabsh_pkg::MODE_ABSORB, 8'h62);
    send_word(shabsh_pkg::MODE_ABSORB, 8'h63);
    send_word(shabsh_pkg::MODE_FINISH, 8'h00);
    // Extreme byte values; finish carries a data byte that must be ignored.
    send_word(shabsh_pkg::MODE_ABSORB, 8'h00);
    send_word(shabsh_pkg::MODE_ABSORB, 8'hff);
    send_word(shabsh_pkg::MODE_ABSORB, 8'h00);
    send_word(shabsh_pkg::MODE_ABSORB, 8'hff);
    send_word(shabsh_pkg::MODE_FINISH, 8'hff);
    send_word(shabsh_pkg::MODE_FINISH, 8'h5a);

    // Hold the sender until the hasher has paid out every digest.
    drain();

    // Padding boundaries: one pad block at 55 bytes, two at 56, the pad marker
    // filling the block at 63, and a block that closes exactly at 64.
    send_message(55);
    send_message(56);
    send_message(63);
    send_message(64);

    // Mostly short messages, now and then one crossing a block boundary.
    while (words_sent < WORD_TARGET) begin
      if ($urandom_range(0, 9) == 0) len = $urandom_range(56, 72);
      else len = $urandom_range(0, 20);
      send_message(len);
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d digest words never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
